/* sv/mbss_pkg.sv */
// Shared constants, types and helpers for the masked byte signature search.
package mbss_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int IMAGE_BYTES = 65536;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 6;
  localparam int OFF_W   = 16;
  localparam int PTR_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W   = $clog2(IMAGE_BYTES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic              care;
    logic [BYTE_W-1:0] value;
  } pat_entry_t;

  // per-cycle commands from the controller to the cell row
  typedef struct packed {
    logic shift;
    logic clear;
    logic rotate;
    logic load;
    ptr_t ptr;
  } chain_ctrl_t;

  // zero reads as one, anything past the row as the full row
  function automatic len_t eff_len(input logic [CFG_W-1:0] v);
    len_t r;
    if (v == '0) begin
      r = len_t'(1);
    end else if (int'(v) > MAX_PATTERN) begin
      r = len_t'(MAX_PATTERN);
    end else begin
      r = len_t'(v);
    end
    return r;
  endfunction

endpackage

/* sv/mbss_ifs.sv */
// Valid/ready channel interfaces for items in and results out.
interface mbss_in_if;
  logic                          valid;
  logic                          ready;
  logic [mbss_pkg::CMD_W-1:0]    cmd;
  logic [mbss_pkg::IDX_W-1:0]    entry_index;
  logic [mbss_pkg::BYTE_W-1:0]   entry_byte;
  logic                          entry_care;
  logic [mbss_pkg::BYTE_W-1:0]   image_byte;

  modport source(output valid, cmd, entry_index, entry_byte, entry_care, image_byte,
                 input ready);
  modport sink(input valid, cmd, entry_index, entry_byte, entry_care, image_byte,
               output ready);
endinterface

interface mbss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [mbss_pkg::OFF_W-1:0]  match_offset;

  modport source(output valid, found, match_offset, input ready);
  modport sink(input valid, found, match_offset, output ready);
endinterface

/* sv/mbss_cell.sv */
// One cell: a window byte, a pattern entry and its local compare.
module mbss_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbss_pkg::chain_ctrl_t        ctrl,
  input  logic                         load_sel,
  input  mbss_pkg::pat_entry_t         load_entry,
  input  logic [mbss_pkg::BYTE_W-1:0]  byte_in,
  output logic [mbss_pkg::BYTE_W-1:0]  byte_out,
  input  mbss_pkg::pat_entry_t         pat_in,
  output mbss_pkg::pat_entry_t         pat_out,
  output logic                         ok
);
  import mbss_pkg::*;

  logic [BYTE_W-1:0] win_r;
  pat_entry_t        pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctrl.clear) begin
      win_r <= '0;
    end else if (ctrl.shift) begin
      win_r <= byte_in;
    end
  end

  // pattern has no reset: unwritten entries are undefined
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      pat_r <= pat_in;
    end else if (load_sel) begin
      pat_r <= load_entry;
    end
  end

  // compare against the byte this cell takes on the shift
  assign ok       = !pat_r.care || (byte_in == pat_r.value);
  assign byte_out = win_r;
  assign pat_out  = pat_r;

endmodule

/* sv/mbss_chain.sv */
// Row of cells: shifting byte window, rotatable pattern, match reduction.
module mbss_chain (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbss_pkg::chain_ctrl_t        ctrl,
  input  mbss_pkg::pat_entry_t         load_entry,
  input  logic [mbss_pkg::BYTE_W-1:0]  new_byte,
  input  mbss_pkg::len_t               len,
  output logic                         all_ok
);
  import mbss_pkg::*;

  logic [BYTE_W-1:0] win   [MAX_PATTERN];
  pat_entry_t        pat   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok;
  logic [MAX_PATTERN-1:0] act;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [BYTE_W-1:0] bin;
    logic              sel;

    if (j == 0) begin : g_head
      assign bin = new_byte;
    end else begin : g_body
      assign bin = win[j-1];
    end

    assign sel    = ctrl.load && (ctrl.ptr == ptr_t'(j));
    assign act[j] = len_t'(j) < len;

    mbss_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .load_sel   (sel),
      .load_entry (load_entry),
      .byte_in    (bin),
      .byte_out   (win[j]),
      .pat_in     (pat[(j + 1) % MAX_PATTERN]),
      .pat_out    (pat[j]),
      .ok         (ok[j])
    );
  end

  // cells past the pattern length always pass
  assign all_ok = &(ok | ~act);

endmodule

/* sv/masked_byte_signature_search.sv */
// Top level: masked byte signature search over a streamed byte image.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  in_ch    | in  | valid/ready          | cmd, entry_index, entry_byte, entry_care,
//           |     |                      | image_byte
//  out_ch   | out | valid/ready          | found, match_offset
//  cfg_*    | in  | cfg_we (no wait)     | cfg_wdata = pattern_length
//
//  One item per cycle. A byte item shifts the window and compares all cells in
//  the same cycle; a report is registered and shows on out_ch the next cycle.
//  Input stalls only while the result register is full and not being taken,
//  and after a length write while the pattern row rotates into its new
//  alignment (one position per cycle).
//  Reset (rst_n low, synchronous) clears the window, counters, result slot and
//  sets length 1; pattern entries are undefined until loaded.
//
// Cell j holds window byte j (newest at 0) and pattern entry (a - j) mod N,
// where a = length - 1. So for every j < length, cell j lines up with the
// pattern position that the window byte of age j is compared against.
module masked_byte_signature_search (
  input  logic                          clk,
  input  logic                          rst_n,
  mbss_in_if.sink                       in_ch,
  mbss_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [mbss_pkg::CFG_W-1:0]    cfg_wdata
);
  import mbss_pkg::*;

  // configuration / alignment
  len_t len_r;
  ptr_t tgt_r;     // wanted alignment: length - 1
  ptr_t algn_r;    // alignment the pattern row currently has
  ptr_t algn_nxt;
  len_t cfg_len;
  logic busy;

  // scan state
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_inc;
  logic             hit_r;
  logic [OFF_W-1:0] off_r;

  // result slot
  logic             out_valid_r;
  logic             found_r;
  logic [OFF_W-1:0] moff_r;

  // item decode
  logic        acc;
  logic        is_load;
  logic        is_byte;
  logic        is_rep;
  logic        sat;
  logic        idx_ok;
  ptr_t        idx_p;
  ptr_t        ld_ptr;
  logic        all_ok;
  logic        hit_now;
  chain_ctrl_t ctrl;
  pat_entry_t  ld_entry;

  assign cfg_len = eff_len(cfg_wdata);
  assign busy    = (algn_r != tgt_r);

  assign in_ch.ready = !busy && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;

  assign sat     = (cnt_r == CNT_W'(IMAGE_BYTES));
  assign is_load = acc && (in_ch.cmd == CMD_LOAD);
  assign is_byte = acc && (in_ch.cmd == CMD_BYTE) && !sat;
  assign is_rep  = acc && (in_ch.cmd == CMD_REPORT);

  // pattern position -> cell under the current alignment
  assign idx_ok = int'(in_ch.entry_index) < MAX_PATTERN;
  assign idx_p  = ptr_t'(in_ch.entry_index);
  assign ld_ptr = (algn_r >= idx_p) ? (algn_r - idx_p)
                                    : (algn_r + ptr_t'(MAX_PATTERN) - idx_p);

  assign algn_nxt = (algn_r == '0) ? ptr_t'(MAX_PATTERN - 1) : (algn_r - 1'b1);

  assign ld_entry.care  = in_ch.entry_care;
  assign ld_entry.value = in_ch.entry_byte;

  assign ctrl.shift  = is_byte;
  assign ctrl.clear  = is_rep;
  assign ctrl.rotate = busy;
  assign ctrl.load   = is_load && idx_ok;
  assign ctrl.ptr    = ld_ptr;

  mbss_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .load_entry (ld_entry),
    .new_byte   (in_ch.image_byte),
    .len        (len_r),
    .all_ok     (all_ok)
  );

  // window must lie fully inside the image
  assign cnt_inc = cnt_r + 1'b1;
  assign hit_now = is_byte && !hit_r && (cnt_inc >= CNT_W'(len_r)) && all_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= len_t'(1);
      tgt_r  <= '0;
      algn_r <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_len;
        tgt_r <= ptr_t'(cfg_len - 1'b1);
      end
      if (busy) begin
        algn_r <= algn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hit_r <= 1'b0;
      off_r <= '0;
    end else if (is_rep) begin
      cnt_r <= '0;
      hit_r <= 1'b0;
      off_r <= '0;
    end else if (is_byte) begin
      cnt_r <= cnt_inc;
      if (hit_now) begin
        hit_r <= 1'b1;
        off_r <= OFF_W'(cnt_inc - CNT_W'(len_r));
      end
    end
  end

  // off_r stays zero until a hit, so no gating on found
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (is_rep) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_rep) begin
      found_r <= hit_r;
      moff_r  <= off_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.match_offset = moff_r;

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("item taken while pattern row rotates");

  a_rep_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_rep |=> (out_ch.valid && out_ch.found == $past(hit_r)))
    else $error("report did not load the result slot");

  a_hit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(hit_r) |-> $past(is_rep))
    else $error("hit state lost without a report");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(IMAGE_BYTES))
    else $error("byte count past image size");
`endif

endmodule
